/* design/sbxks_pkg.sv */
// package of shared types, constants and the letter weight table for the xor key search
package sbxks_pkg;

	localparam int KEY_W     = 8;
	localparam int KEY_COUNT = 1 << KEY_W;
	localparam int SCORE_W   = 23;
	localparam int WEIGHT_W  = 11;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
	localparam logic [KEY_W-1:0]   KEY_LAST  = {KEY_W{1'b1}};

	localparam logic [KEY_W-1:0] UPPER_A = 8'h41;
	localparam logic [KEY_W-1:0] UPPER_Z = 8'h5A;
	localparam logic [KEY_W-1:0] LOWER_A = 8'h61;
	localparam logic [KEY_W-1:0] LOWER_Z = 8'h7A;

	typedef enum logic {
		ST_ACC,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic add;
		logic shift;
	} cell_ctrl_t;

	typedef logic [WEIGHT_W-1:0] weight_t;

	function automatic weight_t letter_weight(input logic [4:0] idx);
		weight_t w;
		begin
			unique case (idx)
				5'd0:    w = 11'd1463;
				5'd1:    w = 11'd104;
				5'd2:    w = 11'd388;
				5'd3:    w = 11'd499;
				5'd4:    w = 11'd1257;
				5'd5:    w = 11'd102;
				5'd6:    w = 11'd130;
				5'd7:    w = 11'd128;
				5'd8:    w = 11'd618;
				5'd9:    w = 11'd40;
				5'd10:   w = 11'd2;
				5'd11:   w = 11'd278;
				5'd12:   w = 11'd474;
				5'd13:   w = 11'd505;
				5'd14:   w = 11'd1073;
				5'd15:   w = 11'd252;
				5'd16:   w = 11'd120;
				5'd17:   w = 11'd653;
				5'd18:   w = 11'd781;
				5'd19:   w = 11'd434;
				5'd20:   w = 11'd463;
				5'd21:   w = 11'd167;
				5'd22:   w = 11'd1;
				5'd23:   w = 11'd21;
				5'd24:   w = 11'd1;
				5'd25:   w = 11'd47;
				default: w = '0;
			endcase
			return w;
		end
	endfunction

	function automatic weight_t weight_of(input logic [KEY_W-1:0] p);
		logic [KEY_W-1:0] up_off;
		logic [KEY_W-1:0] lo_off;
		weight_t w;
		begin
			up_off = p - UPPER_A;
			lo_off = p - LOWER_A;
			if (p >= UPPER_A && p <= UPPER_Z) begin
				w = letter_weight(up_off[4:0]);
			end else if (p >= LOWER_A && p <= LOWER_Z) begin
				w = letter_weight(lo_off[4:0]);
			end else begin
				w = '0;
			end
			return w;
		end
	endfunction

endpackage

/* design/sbxks_cell.sv */
// one key cell: saturating score accumulator that shifts toward the head during the scan
module sbxks_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sbxks_pkg::cell_ctrl_t          ctrl,
	input  logic [sbxks_pkg::KEY_W-1:0]    key_idx,
	input  logic [sbxks_pkg::KEY_W-1:0]    cipher_byte,
	input  logic [sbxks_pkg::SCORE_W-1:0]  shift_in,
	output logic [sbxks_pkg::SCORE_W-1:0]  score
);

	logic [sbxks_pkg::SCORE_W-1:0] score_q;
	logic [sbxks_pkg::SCORE_W:0]   sum;
	logic [sbxks_pkg::SCORE_W-1:0] sat_sum;
	sbxks_pkg::weight_t            w;

	always_comb begin
		w       = sbxks_pkg::weight_of(cipher_byte ^ key_idx);
		sum     = {1'b0, score_q} + {{(sbxks_pkg::SCORE_W + 1 - sbxks_pkg::WEIGHT_W){1'b0}}, w};
		sat_sum = sum[sbxks_pkg::SCORE_W] ? sbxks_pkg::SCORE_MAX : sum[sbxks_pkg::SCORE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
		end else if (ctrl.add) begin
			score_q <= sat_sum;
		end else if (ctrl.shift) begin
			score_q <= shift_in;
		end
	end

	assign score = score_q;

endmodule

/* design/sbxks_best.sv */
// running maximum over the scores leaving the head of the cell chain
module sbxks_best (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           step,
	input  logic [sbxks_pkg::SCORE_W-1:0]  head_score,
	output logic                           scan_last,
	output logic [sbxks_pkg::KEY_W-1:0]    res_key,
	output logic [sbxks_pkg::SCORE_W-1:0]  res_score
);

	logic [sbxks_pkg::KEY_W-1:0]   cnt_q;
	logic [sbxks_pkg::KEY_W-1:0]   key_q;
	logic [sbxks_pkg::SCORE_W-1:0] score_q;
	logic                          take;

	// strict compare keeps the lowest key on a tie
	always_comb begin
		take      = head_score > score_q;
		res_score = take ? head_score : score_q;
		res_key   = take ? cnt_q : key_q;
		scan_last = cnt_q == sbxks_pkg::KEY_LAST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			key_q   <= '0;
			score_q <= '0;
		end else if (start) begin
			cnt_q   <= '0;
			key_q   <= '0;
			score_q <= '0;
		end else if (step) begin
			cnt_q   <= cnt_q + 1'b1;
			key_q   <= res_key;
			score_q <= res_score;
		end
	end

endmodule

/* design/single_byte_xor_key_search_unit.sv */
// top level: row of 256 key cells, head maximum tracker and result register
// non-final bytes are taken one per cycle, all 256 cells adding their weight in parallel
// after the final byte the scores shift out of the cell row into the maximum tracker,
// one key per cycle but for a stall at the last step: the result is valid once that
// step is taken; no byte is taken during the scan, nor while a previous result still
// waits for its transfer at the last scan step; the scan leaves every score at zero
// reset clears all scores, the scan state and the result valid flag
module single_byte_xor_key_search_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [sbxks_pkg::KEY_W-1:0]    cipher_byte,
	input  logic                           last_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [sbxks_pkg::KEY_W-1:0]    win_key,
	output logic [sbxks_pkg::SCORE_W-1:0]  win_score
);

	sbxks_pkg::state_t             state_q;
	sbxks_pkg::state_t             state_nxt;
	sbxks_pkg::cell_ctrl_t         ctrl;
	logic                          in_xfer;
	logic                          start;
	logic                          scan_step;
	logic                          finish;
	logic                          scan_last;
	logic [sbxks_pkg::KEY_W-1:0]   res_key;
	logic [sbxks_pkg::SCORE_W-1:0] res_score;
	logic                          out_valid_q;
	logic [sbxks_pkg::KEY_W-1:0]   win_key_q;
	logic [sbxks_pkg::SCORE_W-1:0] win_score_q;

	logic [sbxks_pkg::SCORE_W-1:0] chain [sbxks_pkg::KEY_COUNT+1];

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			sbxks_pkg::ST_ACC: begin
				if (start) begin
					state_nxt = sbxks_pkg::ST_SCAN;
				end
			end
			sbxks_pkg::ST_SCAN: begin
				if (finish) begin
					state_nxt = sbxks_pkg::ST_ACC;
				end
			end
			default: state_nxt = sbxks_pkg::ST_ACC;
		endcase
	end

	// outputs
	always_comb begin
		in_ready   = state_q == sbxks_pkg::ST_ACC;
		in_xfer    = in_valid && in_ready;
		start      = in_xfer && last_byte;
		// final scan step waits until the result register is free
		scan_step  = (state_q == sbxks_pkg::ST_SCAN)
			&& (!scan_last || !out_valid_q || out_ready);
		finish     = scan_step && scan_last;
		ctrl.add   = in_xfer;
		ctrl.shift = scan_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sbxks_pkg::ST_ACC;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			win_key_q   <= res_key;
			win_score_q <= res_score;
		end
	end

	assign chain[sbxks_pkg::KEY_COUNT] = '0;

	for (genvar k = 0; k < sbxks_pkg::KEY_COUNT; k++) begin : g_cell
		sbxks_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.key_idx     (sbxks_pkg::KEY_W'(k)),
			.cipher_byte (cipher_byte),
			.shift_in    (chain[k+1]),
			.score       (chain[k])
		);
	end

	sbxks_best u_best (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.step       (scan_step),
		.head_score (chain[0]),
		.scan_last  (scan_last),
		.res_key    (res_key),
		.res_score  (res_score)
	);

	assign out_valid = out_valid_q;
	assign win_key   = win_key_q;
	assign win_score = win_score_q;

endmodule

/* tb/xor_key_search_checker.sv */
// checker for the xor key search unit: watches both channels, predicts key results and compares
`timescale 1ns / 100ps
module xor_key_search_checker
	import sbxks_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [KEY_W-1:0]   cipher_byte,
	input  logic               last_byte,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [KEY_W-1:0]   win_key,
	input  logic [SCORE_W-1:0] win_score,
	output int unsigned        fail_count,
	output int unsigned        pending,
	output int unsigned        results_seen
);

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [SCORE_W-1:0] score;
	} key_result_t;

	logic [WEIGHT_W-1:0] freq_tab [26];
	logic [SCORE_W-1:0]  key_score [KEY_COUNT];
	key_result_t         expected_keys [$];
	int unsigned         errors;
	int unsigned         seen;

	initial begin
		freq_tab = '{11'd1463, 11'd104, 11'd388, 11'd499, 11'd1257, 11'd102, 11'd130,
			11'd128, 11'd618, 11'd40, 11'd2, 11'd278, 11'd474, 11'd505, 11'd1073,
			11'd252, 11'd120, 11'd653, 11'd781, 11'd434, 11'd463, 11'd167, 11'd1,
			11'd21, 11'd1, 11'd47};
		errors = 0;
		seen = 0;
		fail_count = 0;
		pending = 0;
		results_seen = 0;
	end

	// letters sit at offsets 1..26 of the 0x40 and 0x60 rows
	function automatic logic [WEIGHT_W-1:0] freq_weight(input logic [KEY_W-1:0] p);
		logic [4:0] pos;
		pos = p[4:0];
		if ((p[7:5] == 3'b010 || p[7:5] == 3'b011) && pos >= 5'd1 && pos <= 5'd26)
			return freq_tab[pos - 5'd1];
		return '0;
	endfunction

	task automatic clear_scores();
		for (int k = 0; k < KEY_COUNT; k++)
			key_score[k] = '0;
	endtask

	task automatic absorb_byte(input logic [KEY_W-1:0] c, input logic is_last);
		logic [SCORE_W:0] sum;
		key_result_t      best;
		for (int k = 0; k < KEY_COUNT; k++) begin
			sum = {1'b0, key_score[k]}
				+ {{(SCORE_W + 1 - WEIGHT_W){1'b0}}, freq_weight(c ^ KEY_W'(k))};
			key_score[k] = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];
		end
		if (is_last) begin
			best = '0;
			// strict compare keeps the lowest key on a tie
			for (int k = 0; k < KEY_COUNT; k++) begin
				if (key_score[k] > best.score) begin
					best.score = key_score[k];
					best.key = KEY_W'(k);
				end
			end
			expected_keys.push_back(best);
			clear_scores();
		end
	endtask

	task automatic compare_result();
		key_result_t want;
		seen++;
		if (expected_keys.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result transfer: key %02h score %0d", win_key, win_score);
		end else begin
			want = expected_keys.pop_front();
			if (want.key !== win_key || want.score !== win_score) begin
				errors++;
				if (errors <= 10)
					$display("result %0d: expected key %02h score %0d, got key %02h score %0d",
						seen, want.key, want.score, win_key, win_score);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scores();
			expected_keys.delete();
		end else begin
			if (out_valid && out_ready)
				compare_result();
			if (in_valid && in_ready)
				absorb_byte(cipher_byte, last_byte);
		end
		fail_count <= errors;
		pending <= expected_keys.size();
		results_seen <= seen;
	end

endmodule

/* tb/testbench.sv */
// testbench top for the xor key search unit: stimulus, idling control, watchdog and verdict
`timescale 1ns / 100ps
module testbench;
	import sbxks_pkg::*;

	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned HOLD_CYCLES = 700;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [KEY_W-1:0]   cipher_byte = '0;
	logic               last_byte = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [KEY_W-1:0]   win_key;
	logic [SCORE_W-1:0] win_score;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned results_seen;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_len = 0;
	int unsigned quiet_cycles = 0;
	int unsigned bytes_sent = 0;
	int unsigned msgs_sent = 0;

	logic [KEY_W-1:0] msg [$];
	string common_text = "etaoin shrdlu cmfwyp vbgkqjxz the and of";

	single_byte_xor_key_search_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cipher_byte (cipher_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.win_key     (win_key),
		.win_score   (win_score)
	);

	xor_key_search_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cipher_byte  (cipher_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.win_key      (win_key),
		.win_score    (win_score),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	always #10 clk = ~clk;

	// receiver: random stalls plus an optional long hold-off
	always @(posedge clk) begin
		if (hold_len != 0) begin
			out_ready <= 1'b0;
			repeat (hold_len) @(posedge clk);
			hold_len = 0;
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no transfer for %0d cycles", quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input logic [KEY_W-1:0] b, input logic is_last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cipher_byte <= b;
		last_byte <= is_last;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_msg();
		for (int i = 0; i < msg.size(); i++)
			send_byte(msg[i], i == msg.size() - 1);
		msgs_sent++;
	endtask

	function automatic logic [KEY_W-1:0] text_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 75)
			return common_text[$urandom_range(common_text.len() - 1)];
		if (r < 90)
			return 8'h41 + 8'($urandom_range(25));
		return 8'h61 + 8'($urandom_range(25));
	endfunction

	task automatic build_random_msg();
		int unsigned kind;
		int unsigned len;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] rep;
		kind = $urandom_range(9);
		len = ($urandom_range(9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
		key = 8'($urandom_range(255));
		rep = 8'($urandom_range(255));
		msg.delete();
		for (int i = 0; i < len; i++) begin
			case (kind)
				6, 7: msg.push_back(8'($urandom_range(255)));
				8: msg.push_back(rep);
				9: msg.push_back($urandom_range(3) == 0 ? 8'($urandom_range(255)) : text_char() ^ key);
				default: msg.push_back(text_char() ^ key);
			endcase
		end
	endtask

	task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct,
		input int unsigned n_bytes);
		int unsigned stop_at;
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at) begin
			build_random_msg();
			send_msg();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single bytes giving ties, extreme bytes, plain text, non-letters
		msg = '{8'h00};
		send_msg();
		msg = '{8'hFF};
		send_msg();
		msg = '{8'h65};
		send_msg();
		msg = '{8'h20, 8'h20, 8'h80};
		send_msg();
		msg = '{8'h48, 8'h65, 8'h6C, 8'h6C, 8'h6F, 8'h20, 8'h57, 8'h4F};
		send_msg();
		msg = '{8'h5A ^ 8'hA5, 8'h7A ^ 8'hA5, 8'h41 ^ 8'hA5, 8'h61 ^ 8'hA5, 8'h40, 8'h7F};
		send_msg();
		msg = '{8'h01, 8'hFE};
		send_msg();

		hold_len = HOLD_CYCLES;
		run_phase(0, 0, 125);
		run_phase(77, 0, 125);
		run_phase(0, 77, 125);
		run_phase(27, 27, 125);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("sent %0d messages in %0d byte transfers, %0d key results compared",
			msgs_sent, bytes_sent, results_seen);
		$display("covered ties, extreme and non-letter bytes, text, idle mixes and a %0d-cycle hold-off",
			HOLD_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d failures, %0d results missing", fail_count, pending);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/sbxks_pkg.sv
design/sbxks_cell.sv
design/sbxks_best.sv
design/single_byte_xor_key_search_unit.sv
tb/xor_key_search_checker.sv
tb/testbench.sv
